FILE: sv/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg: shared definitions for the integer text formatter
// Conversion and flag codes, sequencer states, digit unit control and status,
// ASCII constants and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package itf_pkg;

  // sizes
  localparam int MAX_WIDTH_DEFAULT = 63;
  localparam int VALUE_W           = 64;
  localparam int NUM_DIGITS        = 22;
  localparam int DIGITS_W          = NUM_DIGITS * 4;
  localparam int COUNT_W           = $clog2(NUM_DIGITS + 1);
  localparam int BIT_CNT_W         = $clog2(VALUE_W);

  // conversion codes
  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_OCT  = 3'd2;
  localparam logic [2:0] MODE_HEXL = 3'd3;
  localparam logic [2:0] MODE_HEXU = 3'd4;

  // flag codes
  localparam logic [2:0] FLAG_NONE  = 3'd0;
  localparam logic [2:0] FLAG_LEFT  = 3'd1;
  localparam logic [2:0] FLAG_ZERO  = 3'd2;
  localparam logic [2:0] FLAG_PLUS  = 3'd3;
  localparam logic [2:0] FLAG_SPACE = 3'd4;
  localparam logic [2:0] FLAG_ALT   = 3'd5;

  // ascii
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef enum logic [1:0] {
    PAD_NONE,
    PAD_LEFT,
    PAD_ZERO,
    PAD_RIGHT
  } pad_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CONV,
    ST_NORM,
    ST_PLAN,
    ST_PADL,
    ST_SIGN,
    ST_PADZ,
    ST_DIGS,
    ST_PADR
  } state_t;

  typedef struct packed {
    logic   load;
    radix_t radix;
    logic   step;
    logic   norm;
    logic   shift;
  } dig_ctrl_t;

  typedef struct packed {
    logic               conv_done;
    logic               norm_done;
    logic [COUNT_W-1:0] count;
    logic [3:0]         digit;
  } dig_stat_t;

  // digit value to ascii, hex letters in either case
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else if (upper) begin
      c = CH_UP_A + {4'b0, d} - 8'd10;
    end else begin
      c = CH_LOW_A + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

FILE: sv/itf_digit_unit.sv
// ----------------------------------------------------------------------------
// itf_digit_unit: digit register and shared conversion step
// Holds up to 22 digit nibbles. Decimal runs a shift-and-add-3 step once per
// value bit; octal and hex load directly. Leading zeros are shifted away and
// digits leave from the top nibble.
// ----------------------------------------------------------------------------
module itf_digit_unit (
  input  logic                            clk,
  input  itf_pkg::dig_ctrl_t              ctrl,
  input  logic [itf_pkg::VALUE_W-1:0]     mag,
  output itf_pkg::dig_stat_t              stat
);

  logic [itf_pkg::DIGITS_W-1:0]  digits;
  logic [itf_pkg::DIGITS_W-1:0]  load_val;
  logic [itf_pkg::DIGITS_W-1:0]  dabbled;
  logic [itf_pkg::VALUE_W-1:0]   bin;
  logic [itf_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [itf_pkg::COUNT_W-1:0]   count;
  logic [3:0]                    top;

  assign top = digits[itf_pkg::DIGITS_W-1 -: 4];

  // direct digit split for octal and hex
  always_comb begin
    load_val = '0;
    unique case (ctrl.radix)
      itf_pkg::RADIX_HEX: begin
        for (int i = 0; i < itf_pkg::VALUE_W / 4; i++) begin
          load_val[4*i +: 4] = mag[4*i +: 4];
        end
      end
      itf_pkg::RADIX_OCT: begin
        for (int i = 0; i < itf_pkg::VALUE_W / 3; i++) begin
          load_val[4*i +: 4] = {1'b0, mag[3*i +: 3]};
        end
        load_val[itf_pkg::DIGITS_W-1 -: 4] = {3'b0, mag[itf_pkg::VALUE_W-1]};
      end
      default: begin
        load_val = '0;
      end
    endcase
  end

  // add 3 to every bcd digit of five or more
  always_comb begin
    logic [3:0] nib;
    dabbled = '0;
    for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
      nib = digits[4*i +: 4];
      dabbled[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  // digit register
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      digits  <= load_val;
      bin     <= mag;
      bit_cnt <= '0;
      count   <= itf_pkg::COUNT_W'(itf_pkg::NUM_DIGITS);
    end else if (ctrl.step) begin
      digits  <= {dabbled[itf_pkg::DIGITS_W-2:0], bin[itf_pkg::VALUE_W-1]};
      bin     <= {bin[itf_pkg::VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end else if ((ctrl.norm && !stat.norm_done) || ctrl.shift) begin
      digits  <= {digits[itf_pkg::DIGITS_W-5:0], 4'b0};
      count   <= count - 1'b1;
    end
  end

  assign stat.conv_done = (bit_cnt == itf_pkg::BIT_CNT_W'(itf_pkg::VALUE_W - 1));
  assign stat.norm_done = (top != 4'd0) || (count == itf_pkg::COUNT_W'(1));
  assign stat.count     = count;
  assign stat.digit     = top;

endmodule

FILE: sv/integer_text_formatter_top.sv
// Sequence: accept, load, bit-serial conversion for decimal (skipped for
// octal or hex), dropping up to 21 leading zeros, a planning state, then one
// character per cycle while out_ready is high, passing through empty pad states.
// Requests are taken one at a time, only in idle; each is paced by the bit-serial
// decimal step, the leading-zero shift and the one-character output register.
// Reset: synchronous, clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// integer_text_formatter_top: integer to ascii text conversion
// Takes one conversion request and streams its characters with padding and
// sign placement, marking the final character.
// ----------------------------------------------------------------------------
module integer_text_formatter_top #(
  parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  mode,
  input  logic [2:0]                  flag,
  input  logic [5:0]                  width,
  input  logic                        wide,
  input  logic [itf_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  character,
  output logic                        last
);

  localparam logic [5:0] MaxW = 6'(MAX_WIDTH);

  itf_pkg::state_t    state, state_next;
  itf_pkg::dig_ctrl_t ctrl;
  itf_pkg::dig_stat_t stat;
  itf_pkg::pad_kind_t pad_kind;

  logic [2:0]                  mode_r;
  logic [2:0]                  flag_r;
  logic [5:0]                  w_r;
  logic                        wide_r;
  logic [itf_pkg::VALUE_W-1:0] value_r;

  logic [2:0]                  mode_eff;
  logic [5:0]                  w_eff;
  logic                        signed_mode;
  logic [itf_pkg::VALUE_W-1:0] raw;
  logic                        neg;
  logic [itf_pkg::VALUE_W-1:0] mag;
  itf_pkg::radix_t             radix;

  logic                        upper_r;
  logic                        sign_en;
  logic [7:0]                  sign_char;
  logic [5:0]                  pad_cnt;
  logic [5:0]                  text_len;

  logic                        out_free;
  logic                        pad_active;
  logic                        emit;
  logic                        pad_dec;
  logic [7:0]                  char_next;
  logic                        last_next;

  // request decode
  always_comb begin
    mode_eff    = (mode_r > itf_pkg::MODE_HEXU) ? itf_pkg::MODE_UDEC : mode_r;
    w_eff       = (w_r > MaxW) ? MaxW : w_r;
    signed_mode = (mode_eff == itf_pkg::MODE_SDEC);
    raw         = wide_r ? value_r
                         : {{32{signed_mode & value_r[31]}}, value_r[31:0]};
    neg         = signed_mode & raw[itf_pkg::VALUE_W-1];
    mag         = neg ? (~raw + 1'b1) : raw;
    priority if (mode_eff == itf_pkg::MODE_OCT) begin
      radix = itf_pkg::RADIX_OCT;
    end else if (mode_eff == itf_pkg::MODE_HEXL || mode_eff == itf_pkg::MODE_HEXU) begin
      radix = itf_pkg::RADIX_HEX;
    end else begin
      radix = itf_pkg::RADIX_DEC;
    end
  end

  assign text_len = {1'b0, stat.count} + {5'b0, sign_en};
  assign out_free = !out_valid || out_ready;

  // digit unit
  itf_digit_unit u_digits (
    .clk  (clk),
    .ctrl (ctrl),
    .mag  (mag),
    .stat (stat)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itf_pkg::ST_IDLE: begin
        if (in_valid) state_next = itf_pkg::ST_LOAD;
      end
      itf_pkg::ST_LOAD: begin
        state_next = (radix == itf_pkg::RADIX_DEC) ? itf_pkg::ST_CONV : itf_pkg::ST_NORM;
      end
      itf_pkg::ST_CONV: begin
        if (stat.conv_done) state_next = itf_pkg::ST_NORM;
      end
      itf_pkg::ST_NORM: begin
        if (stat.norm_done) state_next = itf_pkg::ST_PLAN;
      end
      itf_pkg::ST_PLAN: begin
        state_next = itf_pkg::ST_PADL;
      end
      itf_pkg::ST_PADL: begin
        if (!(pad_kind == itf_pkg::PAD_LEFT && pad_cnt != 6'd0)) begin
          state_next = itf_pkg::ST_SIGN;
        end else if (out_free && pad_cnt == 6'd1) begin
          state_next = itf_pkg::ST_SIGN;
        end
      end
      itf_pkg::ST_SIGN: begin
        if (!sign_en || out_free) state_next = itf_pkg::ST_PADZ;
      end
      itf_pkg::ST_PADZ: begin
        if (!(pad_kind == itf_pkg::PAD_ZERO && pad_cnt != 6'd0)) begin
          state_next = itf_pkg::ST_DIGS;
        end else if (out_free && pad_cnt == 6'd1) begin
          state_next = itf_pkg::ST_DIGS;
        end
      end
      itf_pkg::ST_DIGS: begin
        if (out_free && stat.count == itf_pkg::COUNT_W'(1)) state_next = itf_pkg::ST_PADR;
      end
      itf_pkg::ST_PADR: begin
        if (!(pad_kind == itf_pkg::PAD_RIGHT && pad_cnt != 6'd0)) begin
          state_next = itf_pkg::ST_IDLE;
        end else if (out_free && pad_cnt == 6'd1) begin
          state_next = itf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = itf_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    ctrl       = '0;
    ctrl.radix = radix;
    pad_active = 1'b0;
    emit       = 1'b0;
    pad_dec    = 1'b0;
    char_next  = itf_pkg::CH_SPACE;
    last_next  = 1'b0;
    unique case (state)
      itf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      itf_pkg::ST_LOAD: begin
        ctrl.load = 1'b1;
      end
      itf_pkg::ST_CONV: begin
        ctrl.step = 1'b1;
      end
      itf_pkg::ST_NORM: begin
        ctrl.norm = 1'b1;
      end
      itf_pkg::ST_PLAN: begin
        ctrl = '0;
        ctrl.radix = radix;
      end
      itf_pkg::ST_PADL: begin
        pad_active = (pad_kind == itf_pkg::PAD_LEFT) && (pad_cnt != 6'd0);
        emit       = pad_active && out_free;
        pad_dec    = emit;
        char_next  = itf_pkg::CH_SPACE;
      end
      itf_pkg::ST_SIGN: begin
        emit      = sign_en && out_free;
        char_next = sign_char;
      end
      itf_pkg::ST_PADZ: begin
        pad_active = (pad_kind == itf_pkg::PAD_ZERO) && (pad_cnt != 6'd0);
        emit       = pad_active && out_free;
        pad_dec    = emit;
        char_next  = itf_pkg::CH_ZERO;
      end
      itf_pkg::ST_DIGS: begin
        emit       = out_free;
        ctrl.shift = out_free;
        char_next  = itf_pkg::digit_char(stat.digit, upper_r);
        last_next  = (stat.count == itf_pkg::COUNT_W'(1))
                     && !(pad_kind == itf_pkg::PAD_RIGHT && pad_cnt != 6'd0);
      end
      itf_pkg::ST_PADR: begin
        pad_active = (pad_kind == itf_pkg::PAD_RIGHT) && (pad_cnt != 6'd0);
        emit       = pad_active && out_free;
        pad_dec    = emit;
        char_next  = itf_pkg::CH_SPACE;
        last_next  = (pad_cnt == 6'd1);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r  <= mode;
      flag_r  <= flag;
      w_r     <= width;
      wide_r  <= wide;
      value_r <= value;
    end
  end

  // sign and padding plan
  always_ff @(posedge clk) begin
    if (state == itf_pkg::ST_LOAD) begin
      upper_r <= (mode_eff == itf_pkg::MODE_HEXU);
      priority if (neg) begin
        sign_en   <= 1'b1;
        sign_char <= itf_pkg::CH_MINUS;
      end else if (flag_r == itf_pkg::FLAG_PLUS) begin
        sign_en   <= 1'b1;
        sign_char <= itf_pkg::CH_PLUS;
      end else if (flag_r == itf_pkg::FLAG_SPACE && w_eff == 6'd0) begin
        sign_en   <= 1'b1;
        sign_char <= itf_pkg::CH_SPACE;
      end else begin
        sign_en   <= 1'b0;
        sign_char <= itf_pkg::CH_SPACE;
      end
      priority if (w_eff == 6'd0) begin
        pad_kind <= itf_pkg::PAD_NONE;
      end else if (flag_r == itf_pkg::FLAG_NONE || flag_r == itf_pkg::FLAG_SPACE
                   || flag_r == itf_pkg::FLAG_PLUS) begin
        pad_kind <= itf_pkg::PAD_LEFT;
      end else if (flag_r == itf_pkg::FLAG_LEFT) begin
        pad_kind <= itf_pkg::PAD_RIGHT;
      end else if (flag_r == itf_pkg::FLAG_ZERO) begin
        pad_kind <= itf_pkg::PAD_ZERO;
      end else begin
        pad_kind <= itf_pkg::PAD_NONE;
      end
    end
    if (state == itf_pkg::ST_PLAN) begin
      pad_cnt <= (pad_kind != itf_pkg::PAD_NONE && w_eff > text_len) ? w_eff - text_len : 6'd0;
    end else if (pad_dec) begin
      pad_cnt <= pad_cnt - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character <= char_next;
      last      <= last_next;
    end
  end

`ifndef SYNTHESIS
  // leading zeros gone before planning, a lone zero digit stays
  a_norm_done: assert property (@(posedge clk) disable iff (rst)
    state == itf_pkg::ST_PLAN |-> (stat.digit != 4'd0 || stat.count == itf_pkg::COUNT_W'(1)))
    else $error("leading zero digit left at planning");

  // digit count within the register
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state == itf_pkg::ST_PLAN |->
      (stat.count != '0 && stat.count <= itf_pkg::COUNT_W'(itf_pkg::NUM_DIGITS)))
    else $error("digit count out of range");

  // the final character ends the emission
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && last_next) |=> (state == itf_pkg::ST_PADR || state == itf_pkg::ST_IDLE))
    else $error("emission continues after final character");

  // no new request while one is in progress
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  // padding never exceeds the field width
  a_pad_bound: assert property (@(posedge clk) disable iff (rst)
    state == itf_pkg::ST_PADL |-> pad_cnt <= w_eff)
    else $error("padding beyond field width");
`endif

endmodule
